@@ sv/tjlr_pkg.sv @@
// package for the two-joint linear ramp: codes, widths and state types
`timescale 1ns / 1ps

package tjlr_pkg;

    localparam int ANG_W = 32;   // q16.16 angle on the ports
    localparam int DUR_W = 16;   // move length in ticks
    localparam int CNT_W = 17;   // tick counter

    localparam int IN_DATA_W  = 4 * ANG_W + DUR_W;
    localparam int OUT_DATA_W = 2 * ANG_W;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CAPTURE = 2'd1;
    localparam logic [1:0] OP_START   = 2'd2;
    localparam logic [1:0] OP_NOP     = 2'd3;

    localparam logic [DUR_W-1:0] MOVE_LEN_RST = 16'd1000;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PASS,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_ABS,
        DIV_RUN,
        DIV_SIGN
    } t_div_state;

endpackage

@@ sv/two_joint_linear_ramp_unit.sv @@
// two-joint linear ramp: capture, start, tick and no-op items produce one setpoint beat each
// sequencing: tick while moving and capture run one bit-serial pass over the
//   16+FRAC_BITS accumulators, start runs the serial divider (one quotient bit per
//   cycle over ACC_W+1 bits), idle tick and no-op go straight to the output register
// throughput: one item at a time; the next beat is taken once the item's result
//   sits in the output register, even while that result still waits for tready
// reset: synchronous active low; accumulators, steps and goals clear, length 1000
`timescale 1ns / 1ps

module two_joint_linear_ramp_unit import tjlr_pkg::*; #(
    parameter int FRAC_BITS = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // enc_root_angle, enc_tip_angle, target_root, target_tip, duration_ticks
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // opcode
    input  logic [1:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // root_setpoint, tip_setpoint
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // moving, finished
    output logic [1:0]            m_axis_tuser
);

    localparam int ACC_W  = 16 + FRAC_BITS;
    localparam int XSHIFT = FRAC_BITS - 16;
    localparam int DW     = ACC_W + 1;
    localparam int PCW    = $clog2(ACC_W);
    localparam logic [PCW-1:0] PASS_LAST = PCW'(ACC_W - 1);

    // input beat fields
    logic [1:0]              w_op;
    logic signed [ANG_W-1:0] w_enc_root;
    logic signed [ANG_W-1:0] w_enc_tip;
    logic signed [ANG_W-1:0] w_tgt_root;
    logic signed [ANG_W-1:0] w_tgt_tip;
    logic [DUR_W-1:0]        w_dur;

    // control
    t_state          r_state;
    t_state          n_state;
    logic            w_accept;
    logic            w_pass_en;
    logic            w_first;
    logic            w_out_free;
    logic [PCW-1:0]  r_pass_cnt;

    // architectural state
    logic [ACC_W-1:0] r_root;       // root accumulator, shifts during a pass
    logic [ACC_W-1:0] r_tip;        // absolute tip accumulator
    logic [ACC_W-1:0] r_diff;       // tip minus root, rebuilt each pass
    logic [ACC_W-1:0] r_step_root;
    logic [ACC_W-1:0] r_step_tip;
    logic [ACC_W-1:0] r_add_root;   // addend shift registers for the pass
    logic [ACC_W-1:0] r_add_tip;
    logic [ANG_W-1:0] r_goal_root;
    logic [ANG_W-1:0] r_goal_rel;   // goal tip relative to goal root
    logic [DUR_W-1:0] r_move_len;
    logic [CNT_W-1:0] r_tick_cnt;
    logic             r_active;
    logic             r_done;

    // serial datapath
    logic w_sum_root;
    logic w_sum_tip;
    logic w_dbit;

    // divider hookup
    logic signed [ACC_W-1:0] w_tgt_root_acc;
    logic signed [ACC_W-1:0] w_tgt_tip_acc;
    logic signed [ACC_W-1:0] w_enc_root_acc;
    logic signed [ACC_W-1:0] w_enc_tip_acc;
    logic [DW-1:0]           w_dvd_root;
    logic [DW-1:0]           w_dvd_tip;
    logic                    w_div_start;
    logic                    w_div_done;
    logic                    w_div_done_tip;
    logic [ACC_W-1:0]        w_quot_root;
    logic [ACC_W-1:0]        w_quot_tip;

    // tick bookkeeping
    logic [CNT_W-1:0] w_tick_next;
    logic             w_tick_over;

    // result
    logic [ANG_W-1:0] w_root_out;
    logic [ANG_W-1:0] w_tip_out;
    logic             r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [1:0]            r_out_user;

    always_comb begin
        w_op       = s_axis_tuser;
        w_enc_root = s_axis_tdata[ANG_W-1:0];
        w_enc_tip  = s_axis_tdata[2*ANG_W-1:ANG_W];
        w_tgt_root = s_axis_tdata[3*ANG_W-1:2*ANG_W];
        w_tgt_tip  = s_axis_tdata[4*ANG_W-1:3*ANG_W];
        w_dur      = s_axis_tdata[4*ANG_W+DUR_W-1:4*ANG_W];
    end

    // q16.16 to accumulator: sign extend, then move up by the extra fraction bits
    always_comb begin
        w_tgt_root_acc = ACC_W'(w_tgt_root) <<< XSHIFT;
        w_tgt_tip_acc  = ACC_W'(w_tgt_tip) <<< XSHIFT;
        w_enc_root_acc = ACC_W'(w_enc_root) <<< XSHIFT;
        w_enc_tip_acc  = ACC_W'(w_enc_tip) <<< XSHIFT;
        // exact difference, one bit wider than the accumulator
        w_dvd_root = DW'(w_tgt_root_acc) - DW'($signed(r_root));
        w_dvd_tip  = DW'(w_tgt_tip_acc) - DW'($signed(r_tip));
    end

    always_comb begin
        w_tick_next = r_tick_cnt + 1'b1;
        w_tick_over = (w_tick_next > {1'b0, r_move_len});
    end

    // ---------------- sequencer ----------------

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) begin
                if (w_op == OP_START) begin
                    n_state = ST_DIV;
                end else if (w_op == OP_CAPTURE || (w_op == OP_TICK && r_active)) begin
                    n_state = ST_PASS;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_PASS: if (r_pass_cnt == PASS_LAST) begin
                n_state = ST_EMIT;
            end
            ST_DIV: if (w_div_done) begin
                n_state = ST_EMIT;
            end
            ST_EMIT: if (w_out_free) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = (r_state == ST_IDLE);
        w_accept      = s_axis_tvalid && s_axis_tready;
        w_pass_en     = (r_state == ST_PASS);
        w_first       = (r_pass_cnt == '0);
        w_out_free    = !r_out_valid || m_axis_tready;
        w_div_start   = w_accept && (w_op == OP_START);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ---------------- bit-serial pass ----------------
    // root and tip accumulate their addends, and tip minus root is formed
    // from the fresh sum bits in the same cycle, lsb first

    tjlr_bit_add u_add_root (
        .i_clk   (i_clk),
        .i_en    (w_pass_en),
        .i_first (w_first),
        .i_sub   (1'b0),
        .i_a     (r_root[0]),
        .i_b     (r_add_root[0]),
        .o_s     (w_sum_root)
    );

    tjlr_bit_add u_add_tip (
        .i_clk   (i_clk),
        .i_en    (w_pass_en),
        .i_first (w_first),
        .i_sub   (1'b0),
        .i_a     (r_tip[0]),
        .i_b     (r_add_tip[0]),
        .o_s     (w_sum_tip)
    );

    tjlr_bit_add u_sub_rel (
        .i_clk   (i_clk),
        .i_en    (w_pass_en),
        .i_first (w_first),
        .i_sub   (1'b1),
        .i_a     (w_sum_tip),
        .i_b     (w_sum_root),
        .o_s     (w_dbit)
    );

    // ---------------- step dividers ----------------

    tjlr_serial_div #(
        .ACC_W (ACC_W)
    ) u_div_root (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_root),
        .i_divisor  (w_dur),
        .o_done     (w_div_done),
        .o_quot     (w_quot_root)
    );

    tjlr_serial_div #(
        .ACC_W (ACC_W)
    ) u_div_tip (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dvd_tip),
        .i_divisor  (w_dur),
        .o_done     (w_div_done_tip),
        .o_quot     (w_quot_tip)
    );

    // ---------------- state update ----------------

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root      <= '0;
            r_tip       <= '0;
            r_diff      <= '0;
            r_step_root <= '0;
            r_step_tip  <= '0;
            r_goal_root <= '0;
            r_goal_rel  <= '0;
            r_move_len  <= MOVE_LEN_RST;
            r_tick_cnt  <= '0;
            r_active    <= 1'b0;
            r_done      <= 1'b0;
            r_pass_cnt  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: if (w_accept) begin
                    r_pass_cnt <= '0;
                    r_done     <= 1'b0;
                    unique case (w_op)
                        OP_CAPTURE: begin
                            // tip absolute = root + relative tip, summed in the pass
                            r_root     <= w_enc_root_acc;
                            r_tip      <= w_enc_tip_acc;
                            r_add_root <= '0;
                            r_add_tip  <= w_enc_root_acc;
                        end
                        OP_START: begin
                            r_goal_root <= w_tgt_root;
                            r_goal_rel  <= w_tgt_tip - w_tgt_root;
                            r_move_len  <= w_dur;
                            r_tick_cnt  <= '0;
                            r_active    <= 1'b1;
                        end
                        OP_TICK: begin
                            if (r_active) begin
                                r_add_root <= r_step_root;
                                r_add_tip  <= r_step_tip;
                                r_tick_cnt <= w_tick_next;
                                if (w_tick_over) begin
                                    r_active <= 1'b0;
                                    r_done   <= 1'b1;
                                end
                            end else begin
                                r_tick_cnt <= '0;
                            end
                        end
                        OP_NOP: begin
                        end
                        default: begin
                        end
                    endcase
                end
                ST_PASS: begin
                    r_root     <= {w_sum_root, r_root[ACC_W-1:1]};
                    r_tip      <= {w_sum_tip, r_tip[ACC_W-1:1]};
                    r_diff     <= {w_dbit, r_diff[ACC_W-1:1]};
                    r_add_root <= {1'b0, r_add_root[ACC_W-1:1]};
                    r_add_tip  <= {1'b0, r_add_tip[ACC_W-1:1]};
                    r_pass_cnt <= r_pass_cnt + 1'b1;
                end
                ST_DIV: if (w_div_done) begin
                    r_step_root <= w_quot_root;
                    r_step_tip  <= w_quot_tip;
                end
                ST_EMIT: begin
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- result register ----------------

    always_comb begin
        w_root_out = r_done ? r_goal_root : r_root[ACC_W-1 -: ANG_W];
        w_tip_out  = r_done ? r_goal_rel  : r_diff[ACC_W-1 -: ANG_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == ST_EMIT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT && w_out_free) begin
            r_out_data <= {w_tip_out, w_root_out};
            r_out_user <= {r_done, r_active};
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;

`ifndef SYNTH
    // a move in progress never runs past its length
    a_tick_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_tick_cnt <= {1'b0, r_move_len}))
        else $error("tick count beyond move length while moving");

    // both dividers run in lockstep and only report while the sequencer waits
    a_div_lockstep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_div_done != w_div_done_tip) == 1'b0)
        else $error("step dividers out of step");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == ST_DIV))
        else $error("divider finished outside the divide wait");

    // a start beat always launches the dividers
    a_start_divides: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && w_op == OP_START) |=> (r_state == ST_DIV))
        else $error("start beat did not enter the divide wait");

    // the finishing beat reports the move as stopped
    a_finish_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("finished beat still flagged as moving");
`endif

endmodule

@@ sv/tjlr_bit_add.sv @@
// bit-serial adder / subtractor cell, lsb first, carry held in a flop
`timescale 1ns / 1ps

module tjlr_bit_add import tjlr_pkg::*; (
    input  logic i_clk,
    input  logic i_en,
    input  logic i_first,
    input  logic i_sub,
    input  logic i_a,
    input  logic i_b,
    output logic o_s
);

    logic r_carry;
    logic w_b;
    logic w_cin;
    logic n_carry;

    always_comb begin
        w_b     = i_b ^ i_sub;
        w_cin   = i_first ? i_sub : r_carry;
        o_s     = i_a ^ w_b ^ w_cin;
        n_carry = (i_a & w_b) | (i_a & w_cin) | (w_b & w_cin);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_carry <= n_carry;
        end
    end

endmodule

@@ sv/tjlr_serial_div.sv @@
// signed restoring divider, one quotient bit per cycle, quotient truncated toward zero
`timescale 1ns / 1ps

module tjlr_serial_div import tjlr_pkg::*; #(
    parameter int ACC_W = 48
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [ACC_W:0]   i_dividend,
    input  logic [DUR_W-1:0] i_divisor,
    output logic             o_done,
    output logic [ACC_W-1:0] o_quot
);

    localparam int DW = ACC_W + 1;
    localparam int CW = $clog2(DW);
    localparam logic [CW-1:0] LAST = CW'(DW - 1);

    t_div_state r_state;
    t_div_state n_state;

    logic [CW-1:0]    r_cnt;
    logic [DW-1:0]    r_q;
    logic [DUR_W-1:0] r_rem;
    logic [DUR_W-1:0] r_dvs;
    logic             r_neg;

    logic [DUR_W:0]   w_rem_sh;
    logic [DUR_W:0]   w_rem_sub;
    logic             w_ge;
    logic [DW-1:0]    w_quot_s;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            DIV_IDLE: if (i_start) begin
                n_state = DIV_ABS;
            end
            DIV_ABS:  n_state = DIV_RUN;
            DIV_RUN:  if (r_cnt == LAST) begin
                n_state = DIV_SIGN;
            end
            DIV_SIGN: n_state = DIV_IDLE;
            default:  n_state = DIV_IDLE;
        endcase
    end

    always_comb begin
        w_rem_sh  = {r_rem, r_q[DW-1]};
        w_ge      = (w_rem_sh >= {1'b0, r_dvs});
        w_rem_sub = w_rem_sh - {1'b0, r_dvs};
        w_quot_s  = r_neg ? (~r_q + 1'b1) : r_q;
        o_done    = (r_state == DIV_SIGN);
        o_quot    = (r_dvs == '0) ? '0 : w_quot_s[ACC_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DIV_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            DIV_IDLE: if (i_start) begin
                r_q   <= i_dividend;
                r_dvs <= i_divisor;
            end
            DIV_ABS: begin
                // magnitude of the difference, sign kept for the end
                r_neg <= r_q[DW-1];
                r_q   <= r_q[DW-1] ? (~r_q + 1'b1) : r_q;
                r_rem <= '0;
                r_cnt <= '0;
            end
            DIV_RUN: begin
                r_rem <= w_ge ? w_rem_sub[DUR_W-1:0] : w_rem_sh[DUR_W-1:0];
                r_q   <= {r_q[DW-2:0], w_ge};
                r_cnt <= r_cnt + 1'b1;
            end
            DIV_SIGN: begin
            end
            default: begin
            end
        endcase
    end

endmodule

@@ verif/tb_two_joint_linear_ramp_unit.sv @@
// testbench for the two-joint linear ramp: directed and random moves checked against a predictor
`timescale 1ns / 1ps

module tb_two_joint_linear_ramp_unit import tjlr_pkg::*;;

    localparam int FRAC      = 32;
    localparam int ACC_W     = 16 + FRAC;
    localparam int XSH       = FRAC - 16;
    localparam int IDLE_PCT  = 19;
    localparam int STALL_MAX = 2000;   // cycles with no beat on either side
    localparam int TAIL      = 60;     // longest item latency plus margin

    typedef struct packed {
        logic [ANG_W-1:0] root;
        logic [ANG_W-1:0] tip;
        logic             moving;
        logic             finished;
    } t_setpoint;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // enc_root_angle, enc_tip_angle, target_root, target_tip, duration_ticks
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
    // opcode
    logic [1:0]            s_axis_tuser = OP_NOP;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // root_setpoint, tip_setpoint
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    // moving, finished
    logic [1:0]            m_axis_tuser;

    // predictor state
    logic [ACC_W-1:0] pos_root = '0;
    logic [ACC_W-1:0] pos_tip_abs = '0;
    logic [ACC_W-1:0] rate_root = '0;
    logic [ACC_W-1:0] rate_tip = '0;
    logic [ANG_W-1:0] goal_root = '0;
    logic [ANG_W-1:0] goal_tip = '0;
    logic [DUR_W-1:0] span = MOVE_LEN_RST;
    logic [CNT_W-1:0] ticks = '0;
    logic             running = 1'b0;

    t_setpoint setpoint_queue[$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    bit        gaps_on = 1'b1;

    two_joint_linear_ramp_unit #(.FRAC_BITS(FRAC)) dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------- predictor

    function automatic logic [ACC_W-1:0] to_acc(input logic [ANG_W-1:0] q);
        logic signed [ACC_W-1:0] a;
        a = $signed(q);
        return a << XSH;
    endfunction

    // (goal - from) / len, truncated toward zero, wrapped to the accumulator
    function automatic logic [ACC_W-1:0] ramp_rate(input logic [ACC_W-1:0] goal,
                                                   input logic [ACC_W-1:0] from,
                                                   input logic [DUR_W-1:0] len);
        logic signed [ACC_W:0] gap;
        logic [ACC_W:0]        mag;
        logic [ACC_W:0]        quo;
        if (len == '0)
            return '0;
        gap = $signed(goal) - $signed(from);
        mag = gap[ACC_W] ? (~gap + 1'b1) : gap;
        quo = mag / len;
        if (gap[ACC_W])
            quo = ~quo + 1'b1;
        return quo[ACC_W-1:0];
    endfunction

    task automatic predict_setpoint(input logic [1:0] op, input logic [IN_DATA_W-1:0] data);
        logic [ANG_W-1:0] enc_root;
        logic [ANG_W-1:0] enc_tip;
        logic [ACC_W-1:0] rel;
        t_setpoint        sp;
        logic             done;
        enc_root = data[0 +: ANG_W];
        enc_tip  = data[ANG_W +: ANG_W];
        done     = 1'b0;
        case (op)
            OP_CAPTURE: begin
                pos_root    = to_acc(enc_root);
                pos_tip_abs = to_acc(enc_root + enc_tip);
            end
            OP_START: begin
                goal_root = data[2*ANG_W +: ANG_W];
                goal_tip  = data[3*ANG_W +: ANG_W];
                span      = data[4*ANG_W +: DUR_W];
                rate_root = ramp_rate(to_acc(goal_root), pos_root, span);
                rate_tip  = ramp_rate(to_acc(goal_tip), pos_tip_abs, span);
                ticks     = '0;
                running   = 1'b1;
            end
            OP_TICK: begin
                if (running) begin
                    pos_root    = pos_root + rate_root;
                    pos_tip_abs = pos_tip_abs + rate_tip;
                    ticks       = ticks + 1'b1;
                    if (ticks > {1'b0, span}) begin
                        running = 1'b0;
                        done    = 1'b1;
                    end
                end else begin
                    ticks = '0;
                end
            end
            default: ;
        endcase
        if (done) begin
            sp.root = goal_root;
            sp.tip  = goal_tip - goal_root;
        end else begin
            rel     = pos_tip_abs - pos_root;
            sp.root = pos_root[XSH +: ANG_W];
            sp.tip  = rel[XSH +: ANG_W];
        end
        sp.moving   = running;
        sp.finished = done;
        setpoint_queue.push_back(sp);
    endtask

    // ---------------------------------------------------------------- stimulus helpers

    function automatic logic [IN_DATA_W-1:0] pack_payload(input logic [ANG_W-1:0] root,
                                                          input logic [ANG_W-1:0] tip,
                                                          input logic [ANG_W-1:0] troot,
                                                          input logic [ANG_W-1:0] ttip,
                                                          input logic [DUR_W-1:0] len);
        return {len, ttip, troot, tip, root};
    endfunction

    function automatic logic [ANG_W-1:0] pick_angle();
        int r;
        r = $urandom_range(99);
        if (r < 10) return 32'h8000_0000;
        if (r < 20) return 32'h7FFF_FFFF;
        if (r < 40) return ANG_W'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
        return $urandom;
    endfunction

    function automatic logic [DUR_W-1:0] pick_span();
        int r;
        r = $urandom_range(99);
        if (r < 8)  return '0;
        if (r < 75) return DUR_W'($urandom_range(1, 12));
        if (r < 90) return DUR_W'($urandom_range(13, 60));
        return DUR_W'($urandom);
    endfunction

    function automatic logic [IN_DATA_W-1:0] noise_payload();
        return pack_payload($urandom, $urandom, $urandom, $urandom, DUR_W'($urandom));
    endfunction

    function automatic logic [IN_DATA_W-1:0] capture_of(input logic [ANG_W-1:0] root,
                                                        input logic [ANG_W-1:0] tip);
        return pack_payload(root, tip, $urandom, $urandom, DUR_W'($urandom));
    endfunction

    function automatic logic [IN_DATA_W-1:0] move_to(input logic [ANG_W-1:0] troot,
                                                     input logic [ANG_W-1:0] ttip,
                                                     input logic [DUR_W-1:0] len);
        return pack_payload($urandom, $urandom, troot, ttip, len);
    endfunction

    // one input beat; tvalid stays high on return so the next beat can follow directly
    task automatic send_beat(input logic [1:0] op, input logic [IN_DATA_W-1:0] data);
        while (gaps_on && ($urandom_range(99) < IDLE_PCT)) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= data;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_setpoint(op, data);
    endtask

    task automatic send_ticks(input int n);
        repeat (n) send_beat(OP_TICK, noise_payload());
    endtask

    // sender holds off until every pending setpoint has come back
    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (setpoint_queue.size() != 0)
            @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_reset_state();
        send_beat(OP_TICK, noise_payload());
        send_beat(OP_NOP, noise_payload());
    endtask

    task automatic test_capture_extremes();
        send_beat(OP_CAPTURE, capture_of(32'h8000_0000, 32'h8000_0000));
        send_beat(OP_CAPTURE, capture_of(32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_beat(OP_CAPTURE, capture_of(32'hFFFF_FFFF, 32'h0000_0001));
    endtask

    task automatic test_zero_duration();
        send_beat(OP_CAPTURE, capture_of(32'h0012_8000, 32'hFFF0_0000));
        send_beat(OP_START, move_to(32'h8000_0000, 32'h7FFF_FFFF, 16'd0));
        send_ticks(2);   // first tick finishes, second is idle
    endtask

    task automatic test_full_moves();
        // largest positive and negative differences
        send_beat(OP_CAPTURE, capture_of(32'h8000_0000, 32'h0000_0000));
        send_beat(OP_START, move_to(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd3));
        send_ticks(4);
        send_beat(OP_START, move_to(32'h8000_0000, 32'h8000_0001, 16'd1));
        send_ticks(2);
    endtask

    task automatic test_mid_move_changes();
        send_beat(OP_START, move_to(32'h0100_0000, 32'hFF00_0000, 16'd5));
        send_ticks(1);
        // capture near the top so the next step wraps the accumulator
        send_beat(OP_CAPTURE, capture_of(32'h7FFF_0000, 32'h0000_FFFF));
        send_ticks(1);
        send_beat(OP_NOP, noise_payload());
        // restart while moving, with the longest duration
        send_beat(OP_START, move_to(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF));
        send_ticks(2);
    endtask

    task automatic test_random_moves(input int n_items);
        int         sent;
        int         n_ticks;
        int         k;
        logic [1:0] op;
        logic [DUR_W-1:0] len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 10) begin
                // noise: any opcode, any content
                repeat ($urandom_range(1, 4)) begin
                    op = 2'($urandom_range(3));
                    send_beat(op, noise_payload());
                    if (op != OP_NOP) sent++;
                end
            end else begin
                if ($urandom_range(3) != 0) begin
                    send_beat(OP_CAPTURE, capture_of(pick_angle(), pick_angle()));
                    sent++;
                end
                len = pick_span();
                send_beat(OP_START, move_to(pick_angle(), pick_angle(), len));
                sent++;
                if (len > 60)
                    n_ticks = $urandom_range(1, 8);
                else if ($urandom_range(99) < 15)
                    n_ticks = $urandom_range(0, len);     // cut short by the next move
                else
                    n_ticks = len + 1 + $urandom_range(0, 2);
                for (k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(99) < 6) begin
                        if ($urandom_range(1)) begin
                            send_beat(OP_CAPTURE, capture_of(pick_angle(), pick_angle()));
                            sent++;
                        end else begin
                            send_beat(OP_NOP, noise_payload());
                        end
                    end
                    send_beat(OP_TICK, noise_payload());
                    sent++;
                end
            end
        end
    endtask

    // ---------------------------------------------------------------- receiver and checks

    always @(posedge i_clk) begin
        if (!i_rst_n || !gaps_on)
            m_axis_tready <= i_rst_n;
        else
            m_axis_tready <= ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : check_setpoint
        t_setpoint want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (setpoint_queue.size() == 0) begin
                $error("setpoint beat with no item pending");
                mismatch_count++;
            end else begin
                want = setpoint_queue.pop_front();
                if (m_axis_tdata[0 +: ANG_W] !== want.root) begin
                    $error("root_setpoint: expected %h, got %h",
                           want.root, m_axis_tdata[0 +: ANG_W]);
                    mismatch_count++;
                end
                if (m_axis_tdata[ANG_W +: ANG_W] !== want.tip) begin
                    $error("tip_setpoint: expected %h, got %h",
                           want.tip, m_axis_tdata[ANG_W +: ANG_W]);
                    mismatch_count++;
                end
                if (m_axis_tuser[0] !== want.moving) begin
                    $error("moving: expected %b, got %b", want.moving, m_axis_tuser[0]);
                    mismatch_count++;
                end
                if (m_axis_tuser[1] !== want.finished) begin
                    $error("finished: expected %b, got %b", want.finished, m_axis_tuser[1]);
                    mismatch_count++;
                end
            end
        end
    end

    // watchdog: too long without a beat on either side
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_MAX) begin
            $display("status: fail");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // ---------------------------------------------------------------- sequence

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_capture_extremes();
        test_zero_duration();
        wait_for_drain();
        test_full_moves();
        test_mid_move_changes();
        wait_for_drain();

        test_random_moves(700);
        wait_for_drain();
        gaps_on = 1'b0;          // back-to-back stretch on both sides
        test_random_moves(350);
        wait_for_drain();
        gaps_on = 1'b1;
        test_random_moves(700);

        wait_for_drain();
        repeat (TAIL) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
